// ===== hdl/zdrp_pkg.sv =====
// ============================================================================
// ZIP directory record parser package
// Types, header field positions and hash constants shared by the parser.
// ============================================================================
package zdrp_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_KEPT    = 2'd0,
        ST_SKIPPED = 2'd1,
        ST_BAD_SIG = 2'd2
    } status_t;

    // Central directory file header signature and fixed header length.
    localparam logic [31:0] SIG_CDIR = 32'h0201_4b50;
    localparam logic [17:0] HDR_LEN  = 18'd46;

    // Names at or above this length are reported as skipped.
    localparam logic [16:0] NAME_LIMIT = 17'd512;

    // Byte positions inside the fixed header.
    localparam logic [5:0] POS_SIG_END  = 6'd3;
    localparam logic [5:0] POS_METHOD   = 6'd10;
    localparam logic [5:0] POS_CSIZE    = 6'd20;
    localparam logic [5:0] POS_USIZE    = 6'd24;
    localparam logic [5:0] POS_NLEN     = 6'd28;
    localparam logic [5:0] POS_XLEN     = 6'd30;
    localparam logic [5:0] POS_CLEN     = 6'd32;
    localparam logic [5:0] POS_OFFSET   = 6'd42;
    localparam logic [5:0] POS_HDR_LAST = 6'd45;

    // 64-bit FNV-1a offset basis.
    localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

    // One FNV-1a step. The prime is 2^40 + 0x1b3, so the multiply is a
    // handful of shifted adds.
    function automatic logic [63:0] fnv1a_step(input logic [63:0] hash,
                                               input logic [7:0]  data);
        logic [63:0] x;
        x = hash ^ {56'd0, data};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
             + (x << 1) + x;
    endfunction

endpackage

// ===== hdl/zip_directory_record_parser_unit.sv =====
// ============================================================================
// ZIP directory record parser unit
// Walks the ZIP central directory one byte per beat and gives one result beat
// per record: the header fields, an FNV-1a 64 hash of the name and a status.
// It takes one input beat in every clock cycle while s_ready is high. Each
// beat is processed by the logic between the parser state registers and the
// result register, whose longest path is the 64-bit shift-and-add of the
// FNV-1a multiply. A result beat appears on the cycle after the last byte of
// its record is accepted, and input beats keep flowing while a result waits,
// as long as the result register is free or being emptied in the same cycle.
// A beat with start_req set begins a new directory; entry_count sets how many
// records are parsed. A record whose signature is wrong ends the scan with a
// bad signature result, and bytes are then ignored until the next start.
// ============================================================================
module zip_directory_record_parser_unit
    import zdrp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Directory byte stream.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_req,

    // Record results.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_is_last,
    output logic [15:0] m_method,
    output logic [31:0] m_compressed_size,
    output logic [31:0] m_uncompressed_size,
    output logic [31:0] m_local_header_offset,
    output logic [15:0] m_name_length,
    output logic [63:0] m_name_hash
);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    // Configuration and scan state.
    logic [15:0] entry_count_reg;
    phase_t      phase_reg, phase_next, cur_phase;
    logic [17:0] pos_reg, pos_next, cur_pos;
    logic [15:0] rd_reg, rd_next, cur_rd;
    logic [31:0] sig_reg, sig_next, cur_sig;
    logic [15:0] method_reg, method_next, cur_method;
    logic [31:0] csize_reg, csize_next, cur_csize;
    logic [31:0] usize_reg, usize_next, cur_usize;
    logic [31:0] offset_reg, offset_next, cur_offset;
    logic [15:0] nlen_reg, nlen_next, cur_nlen;
    logic [15:0] xlen_reg, xlen_next, cur_xlen;
    logic [15:0] clen_reg, clen_next, cur_clen;
    logic [63:0] hash_reg, hash_next, cur_hash;

    // Result register.
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  status_reg;
    logic        last_reg;
    logic [15:0] out_method_reg;
    logic [31:0] out_csize_reg;
    logic [31:0] out_usize_reg;
    logic [31:0] out_offset_reg;
    logic [15:0] out_nlen_reg;
    logic [63:0] out_hash_reg;

    // Per-beat decode.
    logic        s_accept;
    logic        cfg_write;
    logic [5:0]  hdr_pos;
    logic [5:0]  k_off;
    logic [17:0] total_len;
    logic [18:0] pos_inc;
    logic [17:0] name_off;
    logic        in_name;
    logic        kept;
    logic        rec_last;
    logic        res_valid;
    status_t     res_status;
    logic        res_last;
    logic [63:0] res_hash;

    // Handshakes.
    assign s_accept  = s_valid && s_ready;
    assign s_ready   = !m_valid_reg || m_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = {16'd0, entry_count_reg};

    // A start beat restarts the scan from a clean record.
    assign cur_phase  = s_start_req ? ((entry_count_reg != 16'd0) ? PH_HEADER : PH_IDLE)
                                    : phase_reg;
    assign cur_pos    = s_start_req ? 18'd0 : pos_reg;
    assign cur_rd     = s_start_req ? 16'd0 : rd_reg;
    assign cur_sig    = s_start_req ? 32'd0 : sig_reg;
    assign cur_method = s_start_req ? 16'd0 : method_reg;
    assign cur_csize  = s_start_req ? 32'd0 : csize_reg;
    assign cur_usize  = s_start_req ? 32'd0 : usize_reg;
    assign cur_offset = s_start_req ? 32'd0 : offset_reg;
    assign cur_nlen   = s_start_req ? 16'd0 : nlen_reg;
    assign cur_xlen   = s_start_req ? 16'd0 : xlen_reg;
    assign cur_clen   = s_start_req ? 16'd0 : clen_reg;
    assign cur_hash   = s_start_req ? FNV_BASIS : hash_reg;

    // Position arithmetic for the current byte.
    assign hdr_pos   = cur_pos[5:0];
    assign k_off     = hdr_pos - POS_OFFSET;
    assign total_len = HDR_LEN + {2'd0, cur_nlen} + {2'd0, cur_xlen} + {2'd0, cur_clen};
    assign pos_inc   = {1'b0, cur_pos} + 19'd1;
    assign name_off  = cur_pos - HDR_LEN;
    assign in_name   = (cur_pos >= HDR_LEN) && (name_off < {2'd0, cur_nlen});
    assign kept      = (cur_nlen != 16'd0) && ({1'b0, cur_nlen} < NAME_LIMIT);
    assign rec_last  = ({1'b0, cur_rd} + 17'd1) >= {1'b0, entry_count_reg};

    // Next state and result for one accepted byte.
    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        rd_next     = rd_reg;
        sig_next    = sig_reg;
        method_next = method_reg;
        csize_next  = csize_reg;
        usize_next  = usize_reg;
        offset_next = offset_reg;
        nlen_next   = nlen_reg;
        xlen_next   = xlen_reg;
        clen_next   = clen_reg;
        hash_next   = hash_reg;
        res_valid   = 1'b0;
        res_status  = ST_KEPT;
        res_last    = 1'b0;
        res_hash    = 64'd0;

        if (s_accept) begin
            phase_next  = cur_phase;
            pos_next    = cur_pos;
            rd_next     = cur_rd;
            sig_next    = cur_sig;
            method_next = cur_method;
            csize_next  = cur_csize;
            usize_next  = cur_usize;
            offset_next = cur_offset;
            nlen_next   = cur_nlen;
            xlen_next   = cur_xlen;
            clen_next   = cur_clen;
            hash_next   = cur_hash;

            case (cur_phase)
                PH_HEADER: begin
                    // Field capture, little-endian.
                    sig_next = {s_data_byte, cur_sig[31:8]};
                    if (hdr_pos inside {[POS_METHOD : POS_METHOD + 6'd1]}) begin
                        method_next[8*hdr_pos[0] +: 8] = s_data_byte;
                    end else if (hdr_pos inside {[POS_CSIZE : POS_CSIZE + 6'd3]}) begin
                        csize_next[8*hdr_pos[1:0] +: 8] = s_data_byte;
                    end else if (hdr_pos inside {[POS_USIZE : POS_USIZE + 6'd3]}) begin
                        usize_next[8*hdr_pos[1:0] +: 8] = s_data_byte;
                    end else if (hdr_pos inside {[POS_NLEN : POS_NLEN + 6'd1]}) begin
                        nlen_next[8*hdr_pos[0] +: 8] = s_data_byte;
                    end else if (hdr_pos inside {[POS_XLEN : POS_XLEN + 6'd1]}) begin
                        xlen_next[8*hdr_pos[0] +: 8] = s_data_byte;
                    end else if (hdr_pos inside {[POS_CLEN : POS_CLEN + 6'd1]}) begin
                        clen_next[8*hdr_pos[0] +: 8] = s_data_byte;
                    end else if (hdr_pos inside {[POS_OFFSET : POS_HDR_LAST]}) begin
                        offset_next[8*k_off[1:0] +: 8] = s_data_byte;
                    end

                    if (hdr_pos == POS_SIG_END && sig_next != SIG_CDIR) begin
                        // Bad signature: abort the scan.
                        res_valid  = 1'b1;
                        res_status = ST_BAD_SIG;
                        res_last   = 1'b1;
                        phase_next = PH_IDLE;
                    end else if (hdr_pos == POS_HDR_LAST) begin
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (in_name) begin
                        hash_next = fnv1a_step(cur_hash, s_data_byte);
                    end
                end
                default: begin
                end
            endcase

            // End of record, or advance to the next byte.
            if (!res_valid && cur_phase != PH_IDLE) begin
                if (phase_next == PH_BODY && pos_inc >= {1'b0, total_len}) begin
                    res_valid   = 1'b1;
                    res_status  = kept ? ST_KEPT : ST_SKIPPED;
                    res_last    = rec_last;
                    res_hash    = kept ? hash_next : 64'd0;
                    rd_next     = cur_rd + 16'd1;
                    phase_next  = rec_last ? PH_IDLE : PH_HEADER;
                    pos_next    = 18'd0;
                    sig_next    = 32'd0;
                    hash_next   = FNV_BASIS;
                end else begin
                    pos_next = pos_inc[17:0];
                end
            end
        end
    end

    // The result register empties when taken and loads on a new result.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_accept && res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= 16'd0;
            phase_reg       <= PH_IDLE;
            pos_reg         <= 18'd0;
            rd_reg          <= 16'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_write) begin
                entry_count_reg <= pwdata[15:0];
            end
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            rd_reg      <= rd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Record holds. A start beat clears them before they are used.
    always_ff @(posedge aclk) begin
        sig_reg    <= sig_next;
        method_reg <= method_next;
        csize_reg  <= csize_next;
        usize_reg  <= usize_next;
        offset_reg <= offset_next;
        nlen_reg   <= nlen_next;
        xlen_reg   <= xlen_next;
        clen_reg   <= clen_next;
        hash_reg   <= hash_next;
    end

    // Result payload. An aborted record reports zero fields.
    always_ff @(posedge aclk) begin
        if (s_accept && res_valid) begin
            status_reg <= res_status;
            last_reg   <= res_last;
            if (res_status == ST_BAD_SIG) begin
                out_method_reg <= 16'd0;
                out_csize_reg  <= 32'd0;
                out_usize_reg  <= 32'd0;
                out_offset_reg <= 32'd0;
                out_nlen_reg   <= 16'd0;
                out_hash_reg   <= 64'd0;
            end else begin
                out_method_reg <= method_next;
                out_csize_reg  <= csize_next;
                out_usize_reg  <= usize_next;
                out_offset_reg <= offset_next;
                out_nlen_reg   <= nlen_next;
                out_hash_reg   <= res_hash;
            end
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_status              = status_reg;
    assign m_is_last             = last_reg;
    assign m_method              = out_method_reg;
    assign m_compressed_size     = out_csize_reg;
    assign m_uncompressed_size   = out_usize_reg;
    assign m_local_header_offset = out_offset_reg;
    assign m_name_length         = out_nlen_reg;
    assign m_name_hash           = out_hash_reg;

`ifndef SYNTH
    // An abort always closes the scan and carries no hash.
    a_abort_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_BAD_SIG) |-> (m_is_last && m_name_hash == 64'd0))
        else $error("bad signature result without is_last or with a hash");

    // A skipped record never reports a hash.
    a_skip_no_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_SKIPPED) |-> (m_name_hash == 64'd0))
        else $error("skipped record carries a hash");

    // After the final result of a scan the parser is idle.
    a_last_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && res_valid && res_last) |=> (phase_reg == PH_IDLE))
        else $error("scan continued after its final result");
`endif

endmodule
